// ===== rtl/core/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

    // Operation codes of an input beat.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    // Configuration port geometry and register indexes.
    localparam int PADDR_W = 3;
    localparam logic REG_EXTEND_IDX = 1'b0;
    localparam logic [12:0] EXTEND_RESET = 13'd64;

    // Heap layout constants.
    localparam int TAG_BYTES = 8;
    localparam int RESET_EXT_BYTES = 1024;
    localparam int RESET_EPI = 16 + RESET_EXT_BYTES;
    localparam logic [63:0] PROLOGUE_TAG = 64'd17;
    localparam logic [63:0] EPI_TAG = 64'd1;

    // Small signed constants for the shared adder.
    localparam logic [5:0] K_ZERO = 6'd0;
    localparam logic [5:0] K_ONE  = 6'd1;
    localparam logic [5:0] K_P31  = 6'd31;
    localparam logic [5:0] K_M8   = 6'b111000;

    typedef struct packed {
        logic        func;
        logic [15:0] req_size;
        logic [15:0] free_addr;
    } s_item_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } m_item_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        inv;
        logic [5:0]  k;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffha_mem.sv =====
// Single-port heap word memory with registered read data.
`default_nettype none

module ffha_mem #(
    parameter int WORDS = 8192,
    parameter int WA    = 13
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [WA-1:0] addr,
    input  wire logic [63:0]   wdata,
    output logic      [63:0]   rdata
);

    logic [63:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ffha_alu.sv =====
// Shared 64-bit adder and unsigned comparator of the allocator.
`default_nettype none

module ffha_alu (
    input  wire ffha_pkg::alu_req_t req,
    output logic [63:0]             sum,
    output logic                    carry
);

    logic [63:0] b_eff;
    logic [64:0] full;

    // With inv set and k equal to one, carry is high exactly when a >= b.
    always_comb begin
        b_eff = req.inv ? ~req.b : req.b;
        full  = {1'b0, req.a} + {1'b0, b_eff} + {{59{req.k[5]}}, req.k};
        sum   = full[63:0];
        carry = full[64];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ffha_seq.sv =====
// Sequencer that runs allocate and free requests over the heap memory.
`default_nettype none

module ffha_seq #(
    parameter int HEAP_BYTES = 65536
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cmd_valid,
    input  wire ffha_pkg::s_item_t   cmd,
    output logic                     ready,
    input  wire logic [12:0]         extend_granules,
    input  wire logic                out_free,
    output logic                     res_valid,
    output ffha_pkg::m_item_t        res,
    output logic                     mem_we,
    output logic [$clog2(HEAP_BYTES)-4:0] mem_addr,
    output logic [63:0]              mem_wdata,
    input  wire logic [63:0]         mem_rdata,
    output ffha_pkg::alu_req_t       alu_req,
    input  wire logic [63:0]         alu_sum,
    input  wire logic                alu_carry
);

    localparam int AW    = $clog2(HEAP_BYTES);
    localparam int WA    = AW - 3;
    localparam int WORDS = HEAP_BYTES / 8;
    localparam int LIMIT = HEAP_BYTES / 32 + 1;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam logic [WA-1:0] WI_PRO_HDR = WA'(0);
    localparam logic [WA-1:0] WI_PRO_FTR = WA'(1);
    localparam logic [WA-1:0] WI_BLK_HDR = WA'(2);
    localparam logic [WA-1:0] WI_BLK_FTR = WA'((ffha_pkg::RESET_EPI - 8) / 8);
    localparam logic [WA-1:0] WI_EPI     = WA'(ffha_pkg::RESET_EPI / 8);

    typedef enum logic [42:0] {
        ST_IDLE       = 43'h1 << 0,
        ST_CLR        = 43'h1 << 1,
        ST_DISPATCH   = 43'h1 << 2,
        ST_FF_INIT    = 43'h1 << 3,
        ST_FF_CHK     = 43'h1 << 4,
        ST_FF_SIZE    = 43'h1 << 5,
        ST_FF_NEXT    = 43'h1 << 6,
        ST_AL_FOUND   = 43'h1 << 7,
        ST_SP_RD      = 43'h1 << 8,
        ST_SP_REM     = 43'h1 << 9,
        ST_SP_NH      = 43'h1 << 10,
        ST_SP_USED_NH = 43'h1 << 11,
        ST_SP_PUSH_NH = 43'h1 << 12,
        ST_SP_USED_H  = 43'h1 << 13,
        ST_GR_EXT     = 43'h1 << 14,
        ST_GR_SUM     = 43'h1 << 15,
        ST_GR_CHK     = 43'h1 << 16,
        ST_GR_HDR     = 43'h1 << 17,
        ST_GR_FTR     = 43'h1 << 18,
        ST_GR_PUSH    = 43'h1 << 19,
        ST_FR_MERGE   = 43'h1 << 20,
        ST_FR_PUSH    = 43'h1 << 21,
        ST_DONE       = 43'h1 << 22,
        ST_PS_RD      = 43'h1 << 23,
        ST_PS_HDR     = 43'h1 << 24,
        ST_PS_FTR     = 43'h1 << 25,
        ST_PU_RD      = 43'h1 << 26,
        ST_PU_HDR     = 43'h1 << 27,
        ST_PU_FTR     = 43'h1 << 28,
        ST_UL_RD_PRV  = 43'h1 << 29,
        ST_UL_RD_NXT  = 43'h1 << 30,
        ST_UL_FIX     = 43'h1 << 31,
        ST_UL_BACK    = 43'h1 << 32,
        ST_PH_PREV    = 43'h1 << 33,
        ST_PH_NEXT    = 43'h1 << 34,
        ST_PH_BACK    = 43'h1 << 35,
        ST_MG_RD_H    = 43'h1 << 36,
        ST_MG_RD_PF   = 43'h1 << 37,
        ST_MG_LEFT    = 43'h1 << 38,
        ST_MG_LSIZE   = 43'h1 << 39,
        ST_MG_RD_NH   = 43'h1 << 40,
        ST_MG_RIGHT   = 43'h1 << 41,
        ST_MG_RSIZE   = 43'h1 << 42
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    state_t mret_reg, mret_next;
    logic [WA-1:0] clr_reg, clr_next;
    ffha_pkg::s_item_t cmd_reg, cmd_next;
    logic [16:0] need_reg, need_next;
    logic [16:0] ext_reg, ext_next;
    logic [63:0] p_reg, p_next;
    logic [CW-1:0] n_reg, n_next;
    logic grown_reg, grown_next;
    logic [AW-1:0] h_reg, h_next;
    logic [AW-1:0] nh_reg, nh_next;
    logic [63:0] rem_reg, rem_next;
    logic [AW-1:0] old_reg, old_next;
    logic [63:0] gsum_reg, gsum_next;
    logic [AW-1:0] epi_reg, epi_next;
    logic [63:0] free_head_reg, free_head_next;
    logic [AW-1:0] arg_h_reg, arg_h_next;
    logic [63:0] arg_s_reg, arg_s_next;
    logic [63:0] prv_reg, prv_next;
    logic [63:0] nxt_reg, nxt_next;
    logic [63:0] v_reg, v_next;
    logic [AW-1:0] pp_reg, pp_next;
    logic [AW-1:0] mh_reg, mh_next;
    logic [63:0] ms_reg, ms_next;
    logic [63:0] mx_reg, mx_next;
    logic [AW-1:0] mph_reg, mph_next;
    ffha_pkg::m_item_t res_reg, res_next;

    logic [63:0] rd_size;
    logic [63:0] v_tmp;
    logic [AW-1:0] a_tmp;
    logic [16:0] extmin;

    function automatic logic [63:0] init_word(input logic [WA-1:0] w);
        logic [63:0] val;
        val = '0;
        if (w == WI_PRO_HDR || w == WI_PRO_FTR) begin
            val = ffha_pkg::PROLOGUE_TAG;
        end else if (w == WI_BLK_HDR || w == WI_BLK_FTR) begin
            val = 64'(ffha_pkg::RESET_EXT_BYTES);
        end else if (w == WI_EPI) begin
            val = ffha_pkg::EPI_TAG;
        end
        return val;
    endfunction

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;
    assign rd_size   = {mem_rdata[63:4], 4'b0};
    assign extmin    = {extend_granules, 4'b0};

    always_comb begin
        state_next = state_reg;
        ret_next = ret_reg;
        mret_next = mret_reg;
        clr_next = clr_reg;
        cmd_next = cmd_reg;
        need_next = need_reg;
        ext_next = ext_reg;
        p_next = p_reg;
        n_next = n_reg;
        grown_next = grown_reg;
        h_next = h_reg;
        nh_next = nh_reg;
        rem_next = rem_reg;
        old_next = old_reg;
        gsum_next = gsum_reg;
        epi_next = epi_reg;
        free_head_next = free_head_reg;
        arg_h_next = arg_h_reg;
        arg_s_next = arg_s_reg;
        prv_next = prv_reg;
        nxt_next = nxt_reg;
        v_next = v_reg;
        pp_next = pp_reg;
        mh_next = mh_reg;
        ms_next = ms_reg;
        mx_next = mx_reg;
        mph_next = mph_reg;
        res_next = res_reg;
        mem_we = 1'b0;
        mem_addr = '0;
        mem_wdata = '0;
        alu_req = '0;
        v_tmp = '0;
        a_tmp = '0;
        case (state_reg)
            ST_CLR: begin
                mem_we = 1'b1;
                mem_addr = clr_reg;
                mem_wdata = init_word(clr_reg);
                clr_next = clr_reg + WA'(1);
                if (clr_reg == WA'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                res_next.addr = '0;
                res_next.status = ffha_pkg::ST_OK;
                if (cmd_reg.func == ffha_pkg::FUNC_FREE) begin
                    if (cmd_reg.free_addr == '0) begin
                        res_next.status = ffha_pkg::ST_NULL;
                        state_next = ST_DONE;
                    end else begin
                        alu_req.a = 64'(cmd_reg.free_addr);
                        alu_req.k = ffha_pkg::K_M8;
                        h_next = alu_sum[AW-1:0];
                        arg_h_next = alu_sum[AW-1:0];
                        arg_s_next = '0;
                        ret_next = ST_FR_MERGE;
                        state_next = ST_PU_RD;
                    end
                end else if (cmd_reg.req_size == '0) begin
                    res_next.status = ffha_pkg::ST_ZERO;
                    state_next = ST_DONE;
                end else begin
                    alu_req.a = 64'(cmd_reg.req_size);
                    alu_req.k = ffha_pkg::K_P31;
                    need_next = {alu_sum[16:4], 4'b0};
                    grown_next = 1'b0;
                    state_next = ST_FF_INIT;
                end
            end
            ST_FF_INIT: begin
                p_next = free_head_reg;
                n_next = '0;
                state_next = ST_FF_CHK;
            end
            ST_FF_CHK: begin
                if (n_reg == CW'(LIMIT) || p_reg == '0) begin
                    if (grown_reg) begin
                        res_next.status = ffha_pkg::ST_OOM;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_GR_EXT;
                    end
                end else begin
                    mem_addr = p_reg[AW-1:3] - WA'(1);
                    state_next = ST_FF_SIZE;
                end
            end
            ST_FF_SIZE: begin
                alu_req.a = rd_size;
                alu_req.b = 64'(need_reg);
                alu_req.inv = 1'b1;
                alu_req.k = ffha_pkg::K_ONE;
                if (alu_carry) begin
                    state_next = ST_AL_FOUND;
                end else begin
                    mem_addr = p_reg[AW-1:3] + WA'(1);
                    state_next = ST_FF_NEXT;
                end
            end
            ST_FF_NEXT: begin
                p_next = mem_rdata;
                n_next = n_reg + CW'(1);
                state_next = ST_FF_CHK;
            end
            ST_AL_FOUND: begin
                h_next = p_reg[AW-1:0] - AW'(ffha_pkg::TAG_BYTES);
                arg_h_next = p_reg[AW-1:0] - AW'(ffha_pkg::TAG_BYTES);
                res_next.addr = p_reg[15:0];
                ret_next = ST_SP_RD;
                state_next = ST_UL_RD_PRV;
            end
            ST_SP_RD: begin
                mem_addr = h_reg[AW-1:3];
                state_next = ST_SP_REM;
            end
            ST_SP_REM: begin
                alu_req.a = rd_size;
                alu_req.b = 64'(need_reg);
                alu_req.inv = 1'b1;
                alu_req.k = ffha_pkg::K_ONE;
                rem_next = alu_sum;
                arg_h_next = h_reg;
                if (alu_sum[63:5] != '0) begin
                    nh_next = AW'(64'(h_reg) + 64'(need_reg));
                    arg_s_next = 64'(need_reg);
                    ret_next = ST_SP_NH;
                    state_next = ST_PS_RD;
                end else begin
                    arg_s_next = 64'd1;
                    ret_next = ST_DONE;
                    state_next = ST_PU_RD;
                end
            end
            ST_SP_NH: begin
                arg_h_next = nh_reg;
                arg_s_next = rem_reg;
                ret_next = ST_SP_USED_NH;
                state_next = ST_PS_RD;
            end
            ST_SP_USED_NH: begin
                arg_h_next = nh_reg;
                arg_s_next = '0;
                ret_next = ST_SP_PUSH_NH;
                state_next = ST_PU_RD;
            end
            ST_SP_PUSH_NH: begin
                arg_h_next = nh_reg;
                ret_next = ST_SP_USED_H;
                state_next = ST_PH_PREV;
            end
            ST_SP_USED_H: begin
                arg_h_next = h_reg;
                arg_s_next = 64'd1;
                ret_next = ST_DONE;
                state_next = ST_PU_RD;
            end
            ST_GR_EXT: begin
                alu_req.a = 64'(need_reg);
                alu_req.b = 64'(extmin);
                alu_req.inv = 1'b1;
                alu_req.k = ffha_pkg::K_ONE;
                ext_next = alu_carry ? need_reg : extmin;
                state_next = ST_GR_SUM;
            end
            ST_GR_SUM: begin
                alu_req.a = 64'(epi_reg);
                alu_req.b = 64'(ext_reg);
                gsum_next = alu_sum;
                old_next = epi_reg;
                state_next = ST_GR_CHK;
            end
            ST_GR_CHK: begin
                if (gsum_reg > 64'(HEAP_BYTES - ffha_pkg::TAG_BYTES)) begin
                    res_next.status = ffha_pkg::ST_OOM;
                    state_next = ST_DONE;
                end else begin
                    mem_we = 1'b1;
                    mem_addr = gsum_reg[AW-1:3];
                    mem_wdata = ffha_pkg::EPI_TAG;
                    epi_next = gsum_reg[AW-1:0];
                    grown_next = 1'b1;
                    state_next = ST_GR_HDR;
                end
            end
            ST_GR_HDR: begin
                mem_we = 1'b1;
                mem_addr = old_reg[AW-1:3];
                mem_wdata = 64'(ext_reg);
                state_next = ST_GR_FTR;
            end
            ST_GR_FTR: begin
                mem_we = 1'b1;
                mem_addr = gsum_reg[AW-1:3] - WA'(1);
                mem_wdata = 64'(ext_reg);
                mh_next = old_reg;
                mret_next = ST_GR_PUSH;
                state_next = ST_MG_RD_H;
            end
            ST_GR_PUSH: begin
                arg_h_next = mh_reg;
                ret_next = ST_FF_INIT;
                state_next = ST_PH_PREV;
            end
            ST_FR_MERGE: begin
                mh_next = h_reg;
                mret_next = ST_FR_PUSH;
                state_next = ST_MG_RD_H;
            end
            ST_FR_PUSH: begin
                arg_h_next = mh_reg;
                ret_next = ST_DONE;
                state_next = ST_PH_PREV;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PS_RD: begin
                mem_addr = arg_h_reg[AW-1:3];
                state_next = ST_PS_HDR;
            end
            ST_PS_HDR: begin
                v_tmp = arg_s_reg | {60'b0, mem_rdata[3:0]};
                mem_we = 1'b1;
                mem_addr = arg_h_reg[AW-1:3];
                mem_wdata = v_tmp;
                v_next = v_tmp;
                state_next = (arg_s_reg != '0) ? ST_PS_FTR : ret_reg;
            end
            ST_PS_FTR: begin
                alu_req.a = 64'(arg_h_reg);
                alu_req.b = arg_s_reg;
                alu_req.k = ffha_pkg::K_M8;
                mem_we = 1'b1;
                mem_addr = alu_sum[AW-1:3];
                mem_wdata = v_reg;
                state_next = ret_reg;
            end
            ST_PU_RD: begin
                mem_addr = arg_h_reg[AW-1:3];
                state_next = ST_PU_HDR;
            end
            ST_PU_HDR: begin
                v_tmp = {mem_rdata[63:1], arg_s_reg[0]};
                mem_we = 1'b1;
                mem_addr = arg_h_reg[AW-1:3];
                mem_wdata = v_tmp;
                v_next = v_tmp;
                state_next = (v_tmp[63:4] != '0) ? ST_PU_FTR : ret_reg;
            end
            ST_PU_FTR: begin
                alu_req.a = 64'(arg_h_reg);
                alu_req.b = {v_reg[63:4], 4'b0};
                alu_req.k = ffha_pkg::K_M8;
                mem_we = 1'b1;
                mem_addr = alu_sum[AW-1:3];
                mem_wdata = v_reg;
                state_next = ret_reg;
            end
            ST_UL_RD_PRV: begin
                mem_addr = arg_h_reg[AW-1:3] + WA'(1);
                state_next = ST_UL_RD_NXT;
            end
            ST_UL_RD_NXT: begin
                prv_next = mem_rdata;
                mem_addr = arg_h_reg[AW-1:3] + WA'(2);
                state_next = ST_UL_FIX;
            end
            ST_UL_FIX: begin
                nxt_next = mem_rdata;
                if (prv_reg == '0) begin
                    free_head_next = mem_rdata;
                    mem_we = (mem_rdata != '0);
                    mem_addr = mem_rdata[AW-1:3];
                    mem_wdata = '0;
                    state_next = ret_reg;
                end else begin
                    mem_we = 1'b1;
                    mem_addr = prv_reg[AW-1:3] + WA'(1);
                    mem_wdata = mem_rdata;
                    state_next = (mem_rdata != '0) ? ST_UL_BACK : ret_reg;
                end
            end
            ST_UL_BACK: begin
                mem_we = 1'b1;
                mem_addr = nxt_reg[AW-1:3];
                mem_wdata = prv_reg;
                state_next = ret_reg;
            end
            ST_PH_PREV: begin
                a_tmp = arg_h_reg + AW'(ffha_pkg::TAG_BYTES);
                mem_we = 1'b1;
                mem_addr = a_tmp[AW-1:3];
                mem_wdata = '0;
                pp_next = a_tmp;
                state_next = ST_PH_NEXT;
            end
            ST_PH_NEXT: begin
                mem_we = 1'b1;
                mem_addr = pp_reg[AW-1:3] + WA'(1);
                mem_wdata = free_head_reg;
                if (free_head_reg != '0) begin
                    state_next = ST_PH_BACK;
                end else begin
                    free_head_next = 64'(pp_reg);
                    state_next = ret_reg;
                end
            end
            ST_PH_BACK: begin
                mem_we = 1'b1;
                mem_addr = free_head_reg[AW-1:3];
                mem_wdata = 64'(pp_reg);
                free_head_next = 64'(pp_reg);
                state_next = ret_reg;
            end
            ST_MG_RD_H: begin
                mem_addr = mh_reg[AW-1:3];
                state_next = ST_MG_RD_PF;
            end
            ST_MG_RD_PF: begin
                ms_next = rd_size;
                mem_addr = mh_reg[AW-1:3] - WA'(1);
                state_next = ST_MG_LEFT;
            end
            ST_MG_LEFT: begin
                if (!mem_rdata[0]) begin
                    alu_req.a = 64'(mh_reg);
                    alu_req.b = rd_size;
                    alu_req.inv = 1'b1;
                    alu_req.k = ffha_pkg::K_ONE;
                    mx_next = rd_size;
                    mph_next = alu_sum[AW-1:0];
                    arg_h_next = alu_sum[AW-1:0];
                    ret_next = ST_MG_LSIZE;
                    state_next = ST_UL_RD_PRV;
                end else begin
                    state_next = ST_MG_RD_NH;
                end
            end
            ST_MG_LSIZE: begin
                alu_req.a = ms_reg;
                alu_req.b = mx_reg;
                arg_h_next = mph_reg;
                arg_s_next = alu_sum;
                ms_next = alu_sum;
                mh_next = mph_reg;
                ret_next = ST_MG_RD_NH;
                state_next = ST_PS_RD;
            end
            ST_MG_RD_NH: begin
                alu_req.a = 64'(mh_reg);
                alu_req.b = ms_reg;
                mph_next = alu_sum[AW-1:0];
                mem_addr = alu_sum[AW-1:3];
                state_next = ST_MG_RIGHT;
            end
            ST_MG_RIGHT: begin
                if (!mem_rdata[0]) begin
                    mx_next = rd_size;
                    arg_h_next = mph_reg;
                    ret_next = ST_MG_RSIZE;
                    state_next = ST_UL_RD_PRV;
                end else begin
                    state_next = mret_reg;
                end
            end
            ST_MG_RSIZE: begin
                alu_req.a = ms_reg;
                alu_req.b = mx_reg;
                arg_h_next = mh_reg;
                arg_s_next = alu_sum;
                ret_next = mret_reg;
                state_next = ST_PS_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            ret_reg <= ST_IDLE;
            mret_reg <= ST_IDLE;
            clr_reg <= '0;
            grown_reg <= 1'b0;
            epi_reg <= AW'(ffha_pkg::RESET_EPI);
            free_head_reg <= 64'(24);
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            mret_reg <= mret_next;
            clr_reg <= clr_next;
            grown_reg <= grown_next;
            epi_reg <= epi_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        need_reg <= need_next;
        ext_reg <= ext_next;
        p_reg <= p_next;
        n_reg <= n_next;
        h_reg <= h_next;
        nh_reg <= nh_next;
        rem_reg <= rem_next;
        old_reg <= old_next;
        gsum_reg <= gsum_next;
        arg_h_reg <= arg_h_next;
        arg_s_reg <= arg_s_next;
        prv_reg <= prv_next;
        nxt_reg <= nxt_next;
        v_reg <= v_next;
        pp_reg <= pp_next;
        mh_reg <= mh_next;
        ms_reg <= ms_next;
        mx_reg <= mx_next;
        mph_reg <= mph_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: ports, register, result stage.
`default_nettype none

// Channel   Direction  Payload               Purpose
// s_        in         func/req_size/free_addr  one allocate or free request beat
// m_        out        addr/status           one result beat per request
// APB       in/out     extend_granules       heap growth in 16-byte granules
//
// After reset the heap memory is swept once, one word a cycle, through all
// HEAP_BYTES/8 words (8192 at the default), while s_ready stays low.
// A zero-size request or a free of null finishes without a memory access. Any
// other request runs a sequence of steps plus a read of the size, and of the
// next link when the block is too small, for each free-list block visited, as
// the steps share the single memory port and the one 64-bit adder.
// A growth adds writes of the new epilogue, header and footer, a merge and a second walk of the free list.
// A finished result sits in the output register; the next request beat is
// taken while it waits, and the sequencer holds a later result until the
// register drains.
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES = 65536
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ffha_pkg::s_item_t             s_payload,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ffha_pkg::m_item_t                  m_payload,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ffha_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int WA = AW - 3;

    logic [12:0] extend_reg;
    logic        m_valid_reg;
    ffha_pkg::m_item_t m_payload_reg;

    logic        seq_ready;
    logic        seq_res_valid;
    ffha_pkg::m_item_t seq_res;
    logic        out_free;
    logic        mem_we;
    logic [WA-1:0] mem_addr;
    logic [63:0] mem_wdata;
    logic [63:0] mem_rdata;
    ffha_pkg::alu_req_t alu_req;
    logic [63:0] alu_sum;
    logic        alu_carry;
    logic        reg_hit;

    // The only register sits at word index zero; higher words read as zero.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[ffha_pkg::PADDR_W-1:2] == ffha_pkg::REG_EXTEND_IDX);
    assign prdata  = reg_hit ? {19'b0, extend_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extend_reg <= ffha_pkg::EXTEND_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            extend_reg <= pwdata[12:0];
        end
    end

    // The output register frees up in the same cycle its beat is taken.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = seq_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_res_valid && out_free) begin
            m_payload_reg <= seq_res;
        end
    end

    ffha_seq #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (s_valid && seq_ready),
        .cmd            (s_payload),
        .ready          (seq_ready),
        .extend_granules(extend_reg),
        .out_free       (out_free),
        .res_valid      (seq_res_valid),
        .res            (seq_res),
        .mem_we         (mem_we),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata),
        .alu_req        (alu_req),
        .alu_sum        (alu_sum),
        .alu_carry      (alu_carry)
    );

    ffha_mem #(
        .WORDS(HEAP_BYTES / 8),
        .WA   (WA)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    ffha_alu u_alu (
        .req  (alu_req),
        .sum  (alu_sum),
        .carry(alu_carry)
    );

    // A request beat starts a multi-cycle job, so the next cycle is never ready.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in consecutive cycles");

    // A nonzero address is only ever paired with a successful status.
    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.addr != 16'd0 |-> m_payload.status == ffha_pkg::ST_OK)
        else $error("address returned with a failure status");

    // A finished result waits in the sequencer while the output stage is full.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_res_valid && !out_free |=> seq_res_valid)
        else $error("result dropped while the output stage was full");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench of the first-fit heap allocator core.
`default_nettype none

module tb_top;

    // Cycles with no beat on either channel before the run is declared hung.
    // The reset sweep alone writes all 8192 heap words and a walk of a badly
    // corrupted free list can visit up to 2049 blocks, so the margin is generous.
    localparam int IDLE_LIMIT = 200000;
    localparam int HEAP_WORDS = 8192;
    localparam int WALK_MAX   = 65536 / 32 + 1;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [63:0] TAG64 = 64'(ffha_pkg::TAG_BYTES);

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ffha_pkg::s_item_t s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ffha_pkg::m_item_t m_payload;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ffha_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    first_fit_heap_allocator_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Heap model. It mirrors the allocator's memory word for word, so every
    // request, including frees of bogus addresses, is predicted exactly.
    // Addresses are byte offsets; only their low 16 bits reach the memory.
    // ------------------------------------------------------------------
    logic [63:0] heap_words [HEAP_WORDS];
    logic [63:0] list_head;
    logic [63:0] epi_offset;
    logic [12:0] grow_granules;

    ffha_pkg::m_item_t pending_results [$];
    int unsigned live_blocks [$];
    int unsigned freed_blocks [$];
    int          error_count = 0;
    bit          no_idle = 1'b0;
    int          hold_trigger = 0;

    function automatic logic [63:0] hp_add(logic [63:0] a, logic [63:0] b);
        logic [15:0] s;
        s = a[15:0] + b[15:0];
        return {48'd0, s};
    endfunction

    function automatic logic [63:0] hp_sub(logic [63:0] a, logic [63:0] b);
        logic [15:0] s;
        s = a[15:0] - b[15:0];
        return {48'd0, s};
    endfunction

    function automatic logic [63:0] hp_rd(logic [63:0] a);
        return heap_words[a[15:3]];
    endfunction

    function automatic void hp_wr(logic [63:0] a, logic [63:0] v);
        heap_words[a[15:3]] = v;
    endfunction

    function automatic logic [63:0] hp_size(logic [63:0] h);
        return hp_rd(h) & ~64'hF;
    endfunction

    function automatic bit hp_used(logic [63:0] h);
        logic [63:0] w;
        w = hp_rd(h);
        return w[0];
    endfunction

    // Header and footer carry the same tag word.
    function automatic void hp_set_size(logic [63:0] h, logic [63:0] s);
        logic [63:0] v;
        v = s | (hp_rd(h) & 64'hF);
        hp_wr(h, v);
        if (s != 64'd0) hp_wr(hp_sub(hp_add(h, s), TAG64), v);
    endfunction

    function automatic void hp_set_used(logic [63:0] h, bit u);
        logic [63:0] v;
        logic [63:0] s;
        v = hp_rd(h);
        v[0] = u;
        s = v & ~64'hF;
        hp_wr(h, v);
        if (s != 64'd0) hp_wr(hp_sub(hp_add(h, s), TAG64), v);
    endfunction

    function automatic void hp_unlink(logic [63:0] h);
        logic [63:0] p;
        logic [63:0] prv;
        logic [63:0] nxt;
        p = hp_add(h, TAG64);
        prv = hp_rd(p);
        nxt = hp_rd(hp_add(p, 64'd8));
        if (prv == 64'd0) begin
            list_head = nxt;
            if (nxt != 64'd0) hp_wr(nxt, 64'd0);
        end else begin
            hp_wr(hp_add(prv, 64'd8), nxt);
            if (nxt != 64'd0) hp_wr(nxt, prv);
        end
    endfunction

    function automatic void hp_push(logic [63:0] h);
        logic [63:0] p;
        p = hp_add(h, TAG64);
        hp_wr(p, 64'd0);
        hp_wr(hp_add(p, 64'd8), list_head);
        if (list_head != 64'd0) hp_wr(list_head, p);
        list_head = p;
    endfunction

    // First fit, with the walk bounded so that a looped list ends as a miss.
    function automatic logic [63:0] hp_first_fit(logic [63:0] need);
        logic [63:0] p;
        p = list_head;
        for (int n = 0; n < WALK_MAX; n++) begin
            if (p == 64'd0) return 64'd0;
            if (hp_size(hp_sub(p, TAG64)) >= need) return p;
            p = hp_rd(hp_add(p, 64'd8));
        end
        return 64'd0;
    endfunction

    function automatic logic [63:0] hp_coalesce(logic [63:0] h_in);
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] pf;
        logic [63:0] ps;
        logic [63:0] nh;
        logic [63:0] ns;
        h = h_in;
        s = hp_size(h);
        pf = hp_sub(h, TAG64);
        if (!hp_used(pf)) begin
            ps = hp_size(pf);
            h = hp_sub(h, ps);
            hp_unlink(h);
            hp_set_size(h, s + ps);
            s = hp_size(h);
        end
        nh = hp_add(h, s);
        if (!hp_used(nh)) begin
            ns = hp_size(nh);
            hp_unlink(nh);
            hp_set_size(h, s + ns);
        end
        return h;
    endfunction

    function automatic bit hp_grow(logic [63:0] need);
        logic [63:0] ext;
        logic [63:0] old;
        ext = need;
        old = epi_offset;
        if (ext < 64'd32) ext = 64'd32;
        if (ext < 64'(grow_granules) * 64'd16) ext = 64'(grow_granules) * 64'd16;
        if (old + ext + TAG64 > 64'd65536) return 1'b0;
        epi_offset = old + ext;
        hp_wr(epi_offset, ffha_pkg::EPI_TAG);
        hp_wr(old, ext);
        hp_wr(old + ext - TAG64, ext);
        hp_push(hp_coalesce(old));
        return 1'b1;
    endfunction

    function automatic void hp_carve(logic [63:0] h, logic [63:0] need);
        logic [63:0] rem;
        logic [63:0] nh;
        rem = hp_size(h) - need;
        if (rem >= 64'd32) begin
            nh = hp_add(h, need);
            hp_set_size(h, need);
            hp_set_size(nh, rem);
            hp_set_used(nh, 1'b0);
            hp_push(nh);
        end
        hp_set_used(h, 1'b1);
    endfunction

    function automatic void hp_reset();
        foreach (heap_words[i]) heap_words[i] = '0;
        grow_granules = ffha_pkg::EXTEND_RESET;
        hp_wr(64'd0, ffha_pkg::PROLOGUE_TAG);
        hp_wr(64'd8, ffha_pkg::PROLOGUE_TAG);
        hp_wr(64'd16, 64'(ffha_pkg::RESET_EXT_BYTES));
        hp_wr(64'(16 + ffha_pkg::RESET_EXT_BYTES - ffha_pkg::TAG_BYTES),
              64'(ffha_pkg::RESET_EXT_BYTES));
        epi_offset = 64'(ffha_pkg::RESET_EPI);
        hp_wr(epi_offset, ffha_pkg::EPI_TAG);
        list_head = 64'd24;
    endfunction

    function automatic ffha_pkg::m_item_t hp_serve(ffha_pkg::s_item_t it);
        ffha_pkg::m_item_t r;
        logic [63:0] need;
        logic [63:0] p;
        r.addr = '0;
        r.status = ffha_pkg::ST_OK;
        if (it.func == ffha_pkg::FUNC_ALLOC) begin
            if (it.req_size == 16'd0) begin
                r.status = ffha_pkg::ST_ZERO;
            end else begin
                need = ((64'(it.req_size) + 64'd31) >> 4) << 4;
                if (need < 64'd32) need = 64'd32;
                p = hp_first_fit(need);
                if (p == 64'd0 && hp_grow(need)) p = hp_first_fit(need);
                if (p == 64'd0) begin
                    r.status = ffha_pkg::ST_OOM;
                end else begin
                    hp_unlink(hp_sub(p, TAG64));
                    hp_carve(hp_sub(p, TAG64), need);
                    r.addr = p[15:0];
                end
            end
        end else if (it.free_addr == 16'd0) begin
            r.status = ffha_pkg::ST_NULL;
        end else begin
            p = hp_sub({48'd0, it.free_addr}, TAG64);
            hp_set_used(p, 1'b0);
            hp_push(hp_coalesce(p));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Gaps are mostly short with an occasional long one.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request beat and records the result the heap model expects.
    // Valid stays high across back-to-back beats.
    task automatic send_request(input ffha_pkg::s_item_t it);
        ffha_pkg::m_item_t r;
        int g;
        s_valid <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        r = hp_serve(it);
        pending_results.push_back(r);
        if (it.func == ffha_pkg::FUNC_ALLOC && r.status == ffha_pkg::ST_OK)
            live_blocks.push_back(32'(r.addr));
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic request_alloc(input int unsigned bytes);
        ffha_pkg::s_item_t it;
        it.func = ffha_pkg::FUNC_ALLOC;
        it.req_size = bytes[15:0];
        it.free_addr = 16'($urandom());
        send_request(it);
    endtask

    task automatic request_free(input int unsigned a);
        ffha_pkg::s_item_t it;
        it.func = ffha_pkg::FUNC_FREE;
        it.req_size = 16'($urandom());
        it.free_addr = a[15:0];
        send_request(it);
        if (a != 0) freed_blocks.push_back(a);
    endtask

    // Releases one live block picked at random.
    task automatic free_some_live();
        int idx;
        int unsigned a;
        idx = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[idx];
        live_blocks.delete(idx);
        request_free(a);
    endtask

    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 256);
        if (r < 96) return $urandom_range(257, 4096);
        return $urandom_range(4097, 65535);
    endfunction

    // Sender stops until every outstanding result has been taken, and then
    // waits out any work the core may still have in flight.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // After a drain, one APB write of the growth register followed by a read back.
    task automatic set_extend(input logic [12:0] granules);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ffha_pkg::PADDR_W'(ffha_pkg::REG_EXTEND_IDX) << 2;
        pwdata <= 32'(granules);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        grow_granules = granules;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[12:0] !== granules) begin
            $display("%0t: extend_granules read back expected %0d actual %0d",
                     $time, granules, prdata[12:0]);
            error_count++;
        end
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus a long hold-off on request so the
    // core fills up and has to stall its input.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : rx_stall
        int hold_left;
        int seen_trigger;
        int r;
        if (hold_trigger != seen_trigger) begin
            seen_trigger = hold_trigger;
            hold_left = 400;
        end
        r = $urandom_range(0, 99);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (no_idle || r < 65) begin
            m_ready <= 1'b1;
        end else if (r < 97) begin
            m_ready <= 1'b0;
        end else begin
            hold_left = $urandom_range(10, 40);
            m_ready <= 1'b0;
        end
    end

    // Every result beat is compared with the oldest expectation.
    always @(posedge aclk) begin : result_check
        ffha_pkg::m_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual addr %h status %0d",
                         $time, m_payload.addr, m_payload.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_payload.addr !== want.addr) begin
                    $display("%0t: addr expected %h actual %h",
                             $time, want.addr, m_payload.addr);
                    error_count++;
                end
                if (m_payload.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_payload.status);
                    error_count++;
                end
            end
        end
    end

    // A run that stops moving beats for too long is a failure.
    always @(posedge aclk) begin : watchdog
        int quiet;
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero size, null free, smallest and largest requests, split and no
    // split, growth at the epilogue and coalescing on both sides.
    task automatic test_directed();
        int unsigned a0;
        int unsigned a1;
        int unsigned a2;
        request_alloc(0);
        request_free(0);
        request_alloc(1);
        request_alloc(65535);
        request_alloc(16);
        request_alloc(17);
        request_alloc(900);
        request_alloc(2000);
        drain();
        a0 = live_blocks[0];
        a1 = live_blocks[1];
        a2 = live_blocks[2];
        repeat (3) live_blocks.delete(0);
        request_free(a0);
        request_free(a2);
        request_free(a1);
        while (live_blocks.size() != 0) free_some_live();
        request_alloc(48);
        request_alloc(64000);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering, then the sender
    // waits for every result.
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_trigger++;
        for (int i = 0; i < 24; i++) begin
            if (live_blocks.size() > 0 && i[0]) free_some_live();
            else request_alloc(pick_size());
        end
        no_idle = 1'b0;
        drain();
    endtask

    // Mostly legal traffic: allocations of mixed sizes and frees of live
    // blocks, with a few zero-size requests and null frees mixed in.
    task automatic test_random_traffic(input int n, input bit burst);
        int r;
        int alloc_pct;
        no_idle = burst;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            alloc_pct = (live_blocks.size() > 50) ? 35 : 65;
            if (r < 2) request_alloc(0);
            else if (r < 4) request_free(0);
            else if (live_blocks.size() == 0 || r < alloc_pct) request_alloc(pick_size());
            else free_some_live();
        end
        no_idle = 1'b0;
    endtask

    // Double frees and random-offset frees corrupt the heap amid legal traffic.
    task automatic test_bogus_frees(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30 && freed_blocks.size() > 0)
                request_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
            else if (r < 55) request_free($urandom_range(1, 65535));
            else if (r < 70 && live_blocks.size() > 0) free_some_live();
            else request_alloc(pick_size());
        end
    endtask

    initial begin
        hp_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        set_extend(13'd2);
        test_random_traffic(300, 1'b0);
        test_backpressure();
        set_extend(13'd4096);
        test_random_traffic(250, 1'b1);
        set_extend(13'($urandom_range(2, 4095)));
        test_random_traffic(300, 1'b0);
        set_extend(13'd64);
        test_random_traffic(250, 1'b0);
        test_bogus_frees(150);
        drain();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
